@@ design/bitfield_pixel_premultiply_core_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef BITFIELD_PIXEL_PREMULTIPLY_CORE_MACROS_SVH
`define BITFIELD_PIXEL_PREMULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpp assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpp assertion failed");

`endif

@@ design/bpp_pkg.sv @@
package bpp_pkg;

   localparam int unsigned PixelWidth    = 32;
   localparam int unsigned ChanWidth     = 8;
   localparam int unsigned ShiftWidth    = 5;
   localparam int unsigned RegIndexWidth = 2;

   typedef logic [PixelWidth-1:0] word_type;
   typedef logic [ChanWidth-1:0]  chan_type;
   typedef logic [ShiftWidth-1:0] shift_type;

   typedef enum logic [RegIndexWidth-1:0] {
      REG_RED_MASK   = 2'd0,
      REG_GREEN_MASK = 2'd1,
      REG_BLUE_MASK  = 2'd2
   } reg_index_type;

   localparam word_type RedMaskReset   = 32'h00FF_0000;
   localparam word_type GreenMaskReset = 32'h0000_FF00;
   localparam word_type BlueMaskReset  = 32'h0000_00FF;
   localparam chan_type ChanMax        = 8'hFF;
   localparam logic [15:0] RoundBias   = 16'd127;

   // Position of the lowest set bit; an empty mask gives 0.
   function automatic shift_type low_bit_pos(word_type m);
      shift_type pos;
      pos = '0;
      for (int i = PixelWidth - 1; i >= 0; i--) begin
         if (m[i]) begin
            pos = ShiftWidth'(i);
         end
      end
      return pos;
   endfunction

   // Mask, align to bit 0 and saturate to one byte.
   function automatic chan_type extract_chan(word_type px, word_type m, shift_type sh);
      word_type v;
      v = (px & m) >> sh;
      if (|v[PixelWidth-1:ChanWidth]) begin
         return ChanMax;
      end
      return v[ChanWidth-1:0];
   endfunction

   // (c*a + 127) / 255. The division uses (x + (x >> 8) + 1) >> 8, which is
   // exact for every x below 65535; x here never exceeds 65152.
   function automatic chan_type premul(chan_type c, chan_type a);
      logic [15:0] prod;
      logic [15:0] biased;
      logic [15:0] fold;
      prod   = 16'(c) * 16'(a);
      biased = prod + RoundBias;
      fold   = biased + {8'd0, biased[15:8]} + 16'd1;
      return fold[15:8];
   endfunction

endpackage

@@ design/bitfield_pixel_premultiply_core.sv @@
// Unpacks 32-bit bitfield pixels into premultiplied ARGB8888
// (alpha[31:24], red[23:16], green[15:8], blue[7:0]). Red, green and blue are
// picked out by the three mask registers, and alpha takes every bit none of
// them covers. The block accepts one pixel every cycle unless the output stalls;
// each pixel passes through the input register, then the extract, 8x8 multiply
// and divide-by-255 logic into the result register. The shift amounts are
// registered together with their masks, so a mask write applies to every pixel
// transferred at the same edge as the write or later.
// Writes to register index 3 are ignored; the configuration port is always ready.
`include "bitfield_pixel_premultiply_core_macros.svh"

module bitfield_pixel_premultiply_core
   import bpp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,   // [31:0] pixel_in
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,   // [31:0] pixel_out
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [RegIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_data
);

   word_type  red_mask_ff,    red_mask_in;
   word_type  green_mask_ff,  green_mask_in;
   word_type  blue_mask_ff,   blue_mask_in;
   word_type  alpha_mask_ff,  alpha_mask_in;
   shift_type red_shift_ff,   red_shift_in;
   shift_type green_shift_ff, green_shift_in;
   shift_type blue_shift_ff,  blue_shift_in;
   shift_type alpha_shift_ff, alpha_shift_in;

   logic      pix_valid_ff, pix_valid_in;
   word_type  pix_ff,       pix_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_data_ff,  rsp_data_in;

   logic      out_advance;
   logic      in_advance;
   chan_type  alpha_c;
   chan_type  red_c;
   chan_type  green_c;
   chan_type  blue_c;

   logic      out_stalled;
   logic      rsp_premul_ok;

   assign csr_ready   = 1'b1;
   assign out_advance = !rsp_valid_ff || rsp_tready;
   assign in_advance  = !pix_valid_ff || out_advance;
   assign req_tready  = in_advance;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // Mask registers and their derived shift amounts.
   always_comb begin
      red_mask_in   = red_mask_ff;
      green_mask_in = green_mask_ff;
      blue_mask_in  = blue_mask_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RED_MASK:   red_mask_in   = csr_data;
            REG_GREEN_MASK: green_mask_in = csr_data;
            REG_BLUE_MASK:  blue_mask_in  = csr_data;
            default:        ;
         endcase
      end
      alpha_mask_in  = ~(red_mask_in | green_mask_in | blue_mask_in);
      red_shift_in   = low_bit_pos(red_mask_in);
      green_shift_in = low_bit_pos(green_mask_in);
      blue_shift_in  = low_bit_pos(blue_mask_in);
      alpha_shift_in = low_bit_pos(alpha_mask_in);
   end

   // Datapath from the input register to the result register.
   always_comb begin
      alpha_c = extract_chan(pix_ff, alpha_mask_ff, alpha_shift_ff);
      red_c   = premul(extract_chan(pix_ff, red_mask_ff, red_shift_ff), alpha_c);
      green_c = premul(extract_chan(pix_ff, green_mask_ff, green_shift_ff), alpha_c);
      blue_c  = premul(extract_chan(pix_ff, blue_mask_ff, blue_shift_ff), alpha_c);

      pix_valid_in = pix_valid_ff;
      pix_in       = pix_ff;
      if (in_advance) begin
         pix_valid_in = req_tvalid;
         pix_in       = req_tdata;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_advance) begin
         rsp_valid_in = pix_valid_ff;
         rsp_data_in  = {alpha_c, red_c, green_c, blue_c};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_mask_ff    <= RedMaskReset;
         green_mask_ff  <= GreenMaskReset;
         blue_mask_ff   <= BlueMaskReset;
         alpha_mask_ff  <= ~(RedMaskReset | GreenMaskReset | BlueMaskReset);
         red_shift_ff   <= low_bit_pos(RedMaskReset);
         green_shift_ff <= low_bit_pos(GreenMaskReset);
         blue_shift_ff  <= low_bit_pos(BlueMaskReset);
         alpha_shift_ff <= low_bit_pos(~(RedMaskReset | GreenMaskReset | BlueMaskReset));
         pix_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         red_mask_ff    <= red_mask_in;
         green_mask_ff  <= green_mask_in;
         blue_mask_ff   <= blue_mask_in;
         alpha_mask_ff  <= alpha_mask_in;
         red_shift_ff   <= red_shift_in;
         green_shift_ff <= green_shift_in;
         blue_shift_ff  <= blue_shift_in;
         alpha_shift_ff <= alpha_shift_in;
         pix_valid_ff   <= pix_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pix_ff      <= pix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign out_stalled   = pix_valid_ff && rsp_valid_ff && !rsp_tready;
   assign rsp_premul_ok = (rsp_tdata[23:16] <= rsp_tdata[31:24])
                          && (rsp_tdata[15:8] <= rsp_tdata[31:24])
                          && (rsp_tdata[7:0] <= rsp_tdata[31:24]);

   // A premultiplied channel can never exceed its alpha.
   `BPP_ASSERT_NOW(a_premul_bound, rsp_tvalid, rsp_premul_ok)
   // A pixel waiting behind a stalled result stays in the input register.
   `BPP_ASSERT_NEXT(a_pix_hold, out_stalled, pix_valid_ff && $stable(pix_ff))
   // With both registers full and the output stalled, no transfer is taken.
   `BPP_ASSERT_NOW(a_full_stall, out_stalled, !req_tready)

endmodule
